// ----- src/set_pkg.sv -----
// Package for the scratchpad entry table: operation and status codes,
// request and response payload types, entry mark record, controller state
// and command structs. No dependencies.
package set_pkg;

   typedef enum logic [3:0] {
      OP_FIND       = 4'd0,
      OP_GET_OFFSET = 4'd1,
      OP_ALLOC      = 4'd2,
      OP_INVALIDATE = 4'd3,
      OP_SET_DIRTY  = 4'd4,
      OP_IS_DIRTY   = 4'd5,
      OP_ACQUIRE    = 4'd6,
      OP_RELEASE    = 4'd7,
      OP_SET_LOADED = 4'd8,
      OP_IS_LOADED  = 4'd9,
      OP_SWAPPABLE  = 4'd10,
      OP_POP        = 4'd11,
      OP_PUSH       = 4'd12
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_REF   = 2'd3;

   localparam logic [63:0] ALL_ONES = '1;

   typedef struct packed {
      logic [3:0]  operation;
      logic [63:0] key_address;
      logic [63:0] offset_value;
      logic [7:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [1:0]  status;
   } rsp_type;

   // per-entry marks and reference count, one RAM word per entry
   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic        loaded;
      logic [31:0] refs;
   } meta_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_EXEC,
      S_RESP,
      S_CLEAR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch request
      logic read;       // issue memory reads for the latched request
      logic scan_start; // reset find cursor
      logic scan_step;  // examine one active-list slot
      logic exec;       // apply the operation, build the response
      logic clear_step; // one clearing-pass step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_find;
      logic scan_done;
      logic clear_done;
   } sts_type;

endpackage

// ----- src/set_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module set_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- src/set_ctrl.sv -----
// Controller state machine for the scratchpad entry table.
// Depends on set_pkg.
module set_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output set_pkg::cmd_type cmd,
   input  set_pkg::sts_type sts
);
   import set_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (sts.clear_done) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_READ;
         S_READ:  state_in = sts.is_find ? S_SCAN : S_EXEC;
         S_SCAN:  if (sts.scan_done) state_in = S_EXEC;
         S_EXEC:  state_in = S_RESP;
         S_RESP:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.clear_step = 1'b1;
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_READ: begin
            cmd.read       = 1'b1;
            cmd.scan_start = 1'b1;
         end
         S_SCAN:  cmd.scan_step = 1'b1;
         S_EXEC:  cmd.exec = 1'b1;
         S_RESP:  rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end
endmodule

// ----- src/set_dpath.sv -----
// Datapath: entry marks, counts, positions, address/offset and stacks in
// RAMs, find cursor. Depends on set_pkg and set_ram.
module set_dpath #(
   parameter int ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  set_pkg::req_type req_payload,
   input  set_pkg::cmd_type cmd,
   output set_pkg::sts_type sts,
   output set_pkg::rsp_type rsp_payload
);
   import set_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int MW = $bits(meta_type);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   req_type       req_ff;
   rsp_type       rsp_ff, rsp_in;
   logic [CW-1:0] foc_ff, foc_in, fic_ff, fic_in, act_ff, act_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] clr_ff;
   logic          found_ff, found_in;
   logic [IW-1:0] hit_ff, hit_in;
   logic          s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic [IW-1:0] s2_e_ff;

   // RAM ports
   logic          addr_we, off_we, fos_we, fis_we, act_we, meta_we, pos_we;
   logic [IW-1:0] addr_wa, off_wa, fos_wa, fis_wa, act_wa, meta_wa, pos_wa;
   logic [63:0]   addr_wd, off_wd, fos_wd;
   logic [IW-1:0] fis_wd, act_wd, pos_wd;
   logic [IW-1:0] addr_ra, off_ra, fos_ra, fis_ra, act_ra, meta_ra, pos_ra;
   logic [63:0]   addr_rd, off_rd, fos_rd;
   logic [IW-1:0] fis_rd, act_rd, pos_rd;
   meta_type      meta_rd, meta_wd;

   // request decode
   logic [31:0]   idx_wide;
   logic [IW-1:0] idx;
   logic          idx_ok;
   assign idx_wide = {24'd0, req_ff.entry_index};
   assign idx      = idx_wide[IW-1:0];
   assign idx_ok   = (idx_wide < 32'(ENTRIES)) && meta_rd.valid;

   set_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_addr (.clock, .wr_en(addr_we),
      .wr_addr(addr_wa), .wr_data(addr_wd), .rd_addr(addr_ra), .rd_data(addr_rd));
   set_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_off (.clock, .wr_en(off_we),
      .wr_addr(off_wa), .wr_data(off_wd), .rd_addr(off_ra), .rd_data(off_rd));
   set_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_fos (.clock, .wr_en(fos_we),
      .wr_addr(fos_wa), .wr_data(fos_wd), .rd_addr(fos_ra), .rd_data(fos_rd));
   set_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_fis (.clock, .wr_en(fis_we),
      .wr_addr(fis_wa), .wr_data(fis_wd), .rd_addr(fis_ra), .rd_data(fis_rd));
   set_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_act (.clock, .wr_en(act_we),
      .wr_addr(act_wa), .wr_data(act_wd), .rd_addr(act_ra), .rd_data(act_rd));
   set_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (.clock, .wr_en(meta_we),
      .wr_addr(meta_wa), .wr_data(meta_wd), .rd_addr(meta_ra), .rd_data(meta_rd));
   set_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_pos (.clock, .wr_en(pos_we),
      .wr_addr(pos_wa), .wr_data(pos_wd), .rd_addr(pos_ra), .rd_data(pos_rd));

   // find pipeline: read active_list[scan], then read the address of that entry,
   // then compare with the key; each read is registered. Track entry of each stage.
   logic          issue;
   assign issue = cmd.scan_step && !found_ff && (scan_ff < act_ff);

   assign sts.is_find    = (req_ff.operation == OP_FIND);
   assign sts.clear_done = (clr_ff == IW'(ENTRIES - 1));
   assign sts.scan_done  = cmd.scan_step && !issue && !s1_v_ff && !s2_v_ff;

   logic [IW-1:0] last_pos, pos_idx, last_e;
   logic [CW-1:0] act_m1, fic_m1, foc_m1;
   assign act_m1   = act_ff - 1'b1;
   assign fic_m1   = fic_ff - 1'b1;
   assign foc_m1   = foc_ff - 1'b1;
   assign last_pos = act_m1[IW-1:0];
   assign pos_idx  = pos_rd;
   assign last_e   = act_rd;

   always_comb begin
      scan_in  = scan_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      s1_v_in  = s1_v_ff;
      s2_v_in  = s2_v_ff;
      if (cmd.scan_start) begin
         scan_in = '0; found_in = 1'b0; s1_v_in = 1'b0; s2_v_in = 1'b0;
      end else if (cmd.scan_step) begin
         if (issue) scan_in = scan_ff + 1'b1;
         s1_v_in = issue;
         s2_v_in = s1_v_ff && !found_ff;
         if (s2_v_ff && !found_ff && addr_rd == req_ff.key_address) begin
            found_in = 1'b1; hit_in = s2_e_ff;
            s1_v_in = 1'b0; s2_v_in = 1'b0;
         end
      end
   end

   always_comb begin
      addr_ra = act_rd;
      off_ra  = idx;
      fos_ra  = foc_m1[IW-1:0];
      fis_ra  = fic_m1[IW-1:0];
      act_ra  = cmd.read ? last_pos : scan_ff[IW-1:0];
      meta_ra = idx;
      pos_ra  = idx;

      addr_we = 1'b0; addr_wa = fic_m1[IW-1:0]; addr_wd = req_ff.key_address;
      off_we  = 1'b0; off_wa  = fis_rd;        off_wd  = req_ff.offset_value;
      fos_we  = 1'b0; fos_wa  = foc_ff[IW-1:0]; fos_wd = req_ff.offset_value;
      fis_we  = 1'b0; fis_wa  = fic_ff[IW-1:0]; fis_wd = idx;
      act_we  = 1'b0; act_wa  = act_ff[IW-1:0]; act_wd = fis_rd;
      meta_we = 1'b0; meta_wa = idx;            meta_wd = meta_rd;
      pos_we  = 1'b0; pos_wa  = fis_rd;         pos_wd  = act_ff[IW-1:0];

      fic_in = fic_ff;
      foc_in = foc_ff;
      act_in = act_ff;
      rsp_in = rsp_ff;

      if (cmd.clear_step) begin
         fis_we  = 1'b1; fis_wa  = clr_ff; fis_wd  = clr_ff;
         addr_we = 1'b1; addr_wa = clr_ff; addr_wd = '0;
         meta_we = 1'b1; meta_wa = clr_ff; meta_wd = '0;
      end else if (cmd.exec) begin
         rsp_in.result_value = ALL_ONES;
         rsp_in.status       = ST_OK;
         case (req_ff.operation)
            OP_FIND: begin
               if (found_ff) rsp_in.result_value = 64'(hit_ff);
               else rsp_in.status = ST_EMPTY;
            end
            OP_GET_OFFSET: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else rsp_in.result_value = off_rd;
            end
            OP_ALLOC: begin
               if (fic_ff == '0 || act_ff >= FULL) rsp_in.status = ST_EMPTY;
               else begin
                  addr_we = 1'b1; addr_wa = fis_rd;
                  off_we  = 1'b1;
                  act_we  = 1'b1;
                  meta_we = 1'b1; meta_wa = fis_rd;
                  meta_wd = '0; meta_wd.valid = 1'b1;
                  pos_we  = 1'b1;
                  fic_in  = fic_m1;
                  act_in  = act_ff + 1'b1;
                  rsp_in.result_value = 64'(fis_rd);
               end
            end
            OP_INVALIDATE: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else if (meta_rd.refs != '0) rsp_in.status = ST_REF;
               else begin
                  meta_we = 1'b1;
                  meta_wd.valid = 1'b0; meta_wd.dirty = 1'b0; meta_wd.loaded = 1'b0;
                  // move the last active entry into the freed slot
                  if (act_ff != '0) begin
                     act_we = 1'b1; act_wa = pos_idx; act_wd = last_e;
                     pos_we = 1'b1; pos_wa = last_e;  pos_wd = pos_idx;
                     act_in = act_m1;
                  end
                  if (fic_ff < FULL) begin
                     fis_we = 1'b1;
                     fic_in = fic_ff + 1'b1;
                  end
                  rsp_in.result_value = '0;
               end
            end
            OP_SET_DIRTY: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else begin
                  meta_we = 1'b1; meta_wd.dirty = 1'b1;
                  rsp_in.result_value = '0;
               end
            end
            OP_IS_DIRTY: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else rsp_in.result_value = 64'(meta_rd.dirty);
            end
            OP_ACQUIRE: begin
               if (!idx_ok) begin
                  rsp_in.status = ST_BAD; rsp_in.result_value = '0;
               end else begin
                  meta_we = 1'b1; meta_wd.refs = meta_rd.refs + 32'd1;
                  rsp_in.result_value = 64'd1;
               end
            end
            OP_RELEASE: begin
               if (!idx_ok) begin
                  rsp_in.status = ST_BAD; rsp_in.result_value = '0;
               end else if (meta_rd.refs == '0) begin
                  rsp_in.status = ST_REF; rsp_in.result_value = '0;
               end else begin
                  meta_we = 1'b1; meta_wd.refs = meta_rd.refs - 32'd1;
                  rsp_in.result_value = 64'd1;
               end
            end
            OP_SET_LOADED: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else begin
                  meta_we = 1'b1; meta_wd.loaded = 1'b1;
                  rsp_in.result_value = '0;
               end
            end
            OP_IS_LOADED: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else rsp_in.result_value = 64'(meta_rd.loaded);
            end
            OP_SWAPPABLE: begin
               if (!idx_ok) rsp_in.status = ST_BAD;
               else rsp_in.result_value = 64'(meta_rd.refs == '0);
            end
            OP_POP: begin
               if (foc_ff == '0) rsp_in.status = ST_EMPTY;
               else begin
                  foc_in = foc_m1;
                  rsp_in.result_value = fos_rd;
               end
            end
            OP_PUSH: begin
               if (foc_ff >= FULL) rsp_in.status = ST_EMPTY;
               else begin
                  fos_we = 1'b1;
                  foc_in = foc_ff + 1'b1;
                  rsp_in.result_value = '0;
               end
            end
            default: rsp_in.status = ST_BAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) s2_e_ff <= act_rd;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         foc_ff <= '0; fic_ff <= FULL; act_ff <= '0;
         clr_ff <= '0; scan_ff <= '0; found_ff <= 1'b0;
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         foc_ff   <= foc_in;
         fic_ff   <= fic_in;
         act_ff   <= act_in;
         scan_ff  <= scan_in;
         found_ff <= found_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   assign rsp_payload = rsp_ff;
endmodule

// ----- src/scratchpad_entry_table_core.sv -----
// Top level of the scratchpad entry table: controller plus datapath.
// Depends on set_pkg, set_ctrl, set_dpath.
//
//  channel | direction | payload
//  req     | in        | req_type  (operation, key_address, offset_value, entry_index)
//  rsp     | out       | rsp_type  (result_value, status)
//
// Most operations pass through the read, execute and response states from
// transfer in to response valid; find adds a one-slot-a-cycle scan of
// the active list through the address RAM read port.
// After reset a clearing pass loads the free-index stack and clears the entry
// marks and address words; no request is taken meanwhile. One item is in
// flight at a time; a stalled response holds the block.
module scratchpad_entry_table_core #(
   parameter int ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  set_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output set_pkg::rsp_type rsp_payload
);
   import set_pkg::*;

   cmd_type cmd;
   sts_type sts;

   set_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid,
      .rsp_ready, .cmd, .sts);

   set_dpath #(.ENTRIES(ENTRIES)) u_dpath (.clock, .reset, .req_payload, .cmd,
      .sts, .rsp_payload);
endmodule

// ----- src/set_checker.sv -----
// Port-level checker for the scratchpad entry table, bound to the top level.
// Depends on set_pkg.
module set_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input set_pkg::rsp_type rsp_payload
);
   import set_pkg::*;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped while stalled");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too soon");

   a_ack_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_REF |->
         rsp_payload.result_value == '0 || rsp_payload.result_value == ALL_ONES)
      else $error("bad result for referenced status");
endmodule

bind scratchpad_entry_table_core set_checker u_checker (.clock, .reset, .req_valid,
   .req_ready, .rsp_valid, .rsp_ready, .rsp_payload);
